FILE: src/lav_pkg.sv
// Shared types and constants of the look-at view matrix unit.
// Used by every module of the block; depends on nothing.
package lav_pkg;

    // Depth of the queue between front and back.
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // Row codes of the emitted matrix rows.
    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_FWD  = 2'd2;

    // One classified input word as it waits in the queue.
    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][31:0] up;
        logic [2:0][32:0] dir;
        logic             fwd_zero;
    } item_t;

    // Status of the normalize unit.
    typedef struct packed {
        logic done;
        logic zero;
    } norm_stat_t;

    // One result word.
    typedef struct packed {
        logic [1:0]       row_index;
        logic [2:0][31:0] axis;
        logic [31:0]      offset;
        logic             degenerate;
        logic             last_row;
    } row_t;

endpackage

FILE: src/lav_front.sv
// Front part: takes a command word, forms target - eye and flags a zero forward.
// Depends on lav_pkg.
module lav_front (
    input  logic                start,
    input  logic                q_full,
    input  logic signed [31:0]  eye_x,
    input  logic signed [31:0]  eye_y,
    input  logic signed [31:0]  eye_z,
    input  logic signed [31:0]  target_x,
    input  logic signed [31:0]  target_y,
    input  logic signed [31:0]  target_z,
    input  logic signed [31:0]  up_x,
    input  logic signed [31:0]  up_y,
    input  logic signed [31:0]  up_z,
    output logic                busy,
    output logic                push,
    output lav_pkg::item_t      item
);

    logic signed [32:0] dir_x;
    logic signed [32:0] dir_y;
    logic signed [32:0] dir_z;

    // Direction is exact in 33 bits.
    assign dir_x = 33'(target_x) - 33'(eye_x);
    assign dir_y = 33'(target_y) - 33'(eye_y);
    assign dir_z = 33'(target_z) - 33'(eye_z);

    // A word is taken whenever the queue has room.
    assign busy = q_full;
    assign push = start && !q_full;

    // Pack the word and mark an eye that sits on the target.
    always_comb
    begin
        item.eye      = {eye_z, eye_y, eye_x};
        item.up       = {up_z, up_y, up_x};
        item.dir      = {dir_z, dir_y, dir_x};
        item.fwd_zero = (dir_x == 33'sd0) && (dir_y == 33'sd0) && (dir_z == 33'sd0);
    end

endmodule

FILE: src/lav_queue.sv
// Short queue of classified words between the front and the back part.
// Depends on lav_pkg for the word type and the depth.
module lav_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lav_pkg::item_t  din,
    input  logic            pop,
    output lav_pkg::item_t  dout,
    output logic            full,
    output logic            empty
);

    lav_pkg::item_t                    mem_reg [lav_pkg::QDEPTH];
    logic [lav_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [lav_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [lav_pkg::QCNT_W-1:0]        count_reg;
    logic [lav_pkg::QCNT_W-1:0]        count_next;

    assign full  = (count_reg == lav_pkg::QCNT_W'(lav_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    // Fill level follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers wrap at the depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                if (wr_ptr_reg == lav_pkg::QPTR_W'(lav_pkg::QDEPTH - 1))
                begin
                    wr_ptr_reg <= '0;
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (pop)
            begin
                if (rd_ptr_reg == lav_pkg::QPTR_W'(lav_pkg::QDEPTH - 1))
                begin
                    rd_ptr_reg <= '0;
                end
                else
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: src/lav_norm.sv
// Normalize unit: scales a three-component vector to Q2.30 unit length with a
// one-bit-per-cycle square root and divider. Depends on lav_pkg.
module lav_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0][63:0]    vin,
    output lav_pkg::norm_stat_t stat,
    output logic [2:0][31:0]    vout
);

    typedef enum logic [4:0] {
        N_IDLE  = 5'b00001,
        N_SHIFT = 5'b00010,
        N_SQ    = 5'b00100,
        N_SQRT  = 5'b01000,
        N_DIV   = 5'b10000
    } nstate_t;

    nstate_t        state_reg;
    logic [63:0]    mag_reg [3];
    logic [2:0]     neg_reg;
    logic [61:0]    sum_reg;
    logic [59:0]    sq_prod_reg;
    logic           sq_valid_reg;
    logic [1:0]     sq_k_reg;
    logic [62:0]    root_reg;
    logic [62:0]    bit_reg;
    logic [4:0]     cnt_reg;
    logic [1:0]     ci_reg;
    logic [30:0]    rem_reg;
    logic [30:0]    dlow_reg;
    logic [30:0]    quo_reg;
    logic           done_reg;
    logic           zero_reg;
    logic [31:0]    out_reg [3];

    logic [63:0]    mag_max;
    logic [63:0]    root_plus;
    logic           root_ge;
    logic [30:0]    len;
    logic [60:0]    dividend;
    logic [31:0]    rem_sh;
    logic           div_ge;
    logic [30:0]    quo_fin;

    // Largest magnitude of the three.
    always_comb
    begin
        mag_max = mag_reg[0];
        if (mag_reg[1] > mag_max)
        begin
            mag_max = mag_reg[1];
        end
        if (mag_reg[2] > mag_max)
        begin
            mag_max = mag_reg[2];
        end
    end

    // One square-root step and one restoring-division step.
    assign root_plus = {1'b0, root_reg} + {1'b0, bit_reg};
    assign root_ge   = {2'b00, sum_reg} >= root_plus;
    assign len       = root_reg[30:0];
    assign dividend  = {1'b0, mag_reg[ci_reg][29:0], 30'd0} + {31'd0, len[30:1]};
    assign rem_sh    = {rem_reg, dlow_reg[30]};
    assign div_ge    = rem_sh >= {1'b0, len};
    assign quo_fin   = {quo_reg[29:0], div_ge};

    assign stat.done = done_reg;
    assign stat.zero = zero_reg;
    assign vout      = {out_reg[2], out_reg[1], out_reg[0]};

    // Sequencer: shift to range (or flag a zero vector), sum of squares, root, then three quotients.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= N_IDLE;
            done_reg     <= 1'b0;
            zero_reg     <= 1'b0;
            sq_valid_reg <= 1'b0;
            sq_k_reg     <= '0;
            cnt_reg      <= '0;
            ci_reg       <= '0;
            neg_reg      <= '0;
            sum_reg      <= '0;
            sq_prod_reg  <= '0;
            root_reg     <= '0;
            bit_reg      <= '0;
            rem_reg      <= '0;
            dlow_reg     <= '0;
            quo_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= '0;
                out_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            neg_reg[i] <= vin[i][63];
                            mag_reg[i] <= vin[i][63] ? (~vin[i] + 64'd1) : vin[i];
                        end
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    if (mag_max == '0)
                    begin
                        zero_reg  <= 1'b1;
                        done_reg  <= 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            out_reg[i] <= '0;
                        end
                        state_reg <= N_IDLE;
                    end
                    else if (mag_max[63:30] != '0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            mag_reg[i] <= mag_reg[i] >> 1;
                        end
                    end
                    else if (!mag_max[29])
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            mag_reg[i] <= mag_reg[i] << 1;
                        end
                    end
                    else
                    begin
                        sum_reg      <= '0;
                        sq_k_reg     <= '0;
                        sq_valid_reg <= 1'b0;
                        state_reg    <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    // Square one component a cycle, add it the cycle after.
                    sq_valid_reg <= 1'b0;
                    if (sq_k_reg != 2'd3)
                    begin
                        sq_prod_reg  <= mag_reg[sq_k_reg][29:0] * mag_reg[sq_k_reg][29:0];
                        sq_valid_reg <= 1'b1;
                        sq_k_reg     <= sq_k_reg + 1'b1;
                    end
                    if (sq_valid_reg)
                    begin
                        sum_reg <= sum_reg + {2'b00, sq_prod_reg};
                    end
                    if (sq_k_reg == 2'd3 && !sq_valid_reg)
                    begin
                        root_reg  <= '0;
                        bit_reg   <= {1'b1, 62'd0};
                        cnt_reg   <= '0;
                        state_reg <= N_SQRT;
                    end
                end
                N_SQRT:
                begin
                    if (root_ge)
                    begin
                        sum_reg  <= sum_reg - root_plus[61:0];
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31)
                    begin
                        ci_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= N_DIV;
                    end
                end
                N_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        // Load the rounded dividend of this component.
                        rem_reg  <= {1'b0, dividend[60:31]};
                        dlow_reg <= dividend[30:0];
                        quo_reg  <= '0;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        rem_reg  <= div_ge ? 31'(rem_sh - {1'b0, len}) : rem_sh[30:0];
                        dlow_reg <= {dlow_reg[29:0], 1'b0};
                        quo_reg  <= quo_fin;
                        cnt_reg  <= cnt_reg + 1'b1;
                        if (cnt_reg == 5'd31)
                        begin
                            out_reg[ci_reg] <= neg_reg[ci_reg] ? (32'd0 - {1'b0, quo_fin})
                                                               : {1'b0, quo_fin};
                            cnt_reg <= '0;
                            if (ci_reg == 2'd2)
                            begin
                                zero_reg  <= 1'b0;
                                done_reg  <= 1'b1;
                                state_reg <= N_IDLE;
                            end
                            else
                            begin
                                ci_reg <= ci_reg + 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/lav_back.sv
// Back part: runs the two normalizations, both cross products and the eye
// dot products, then sends the three rows. Depends on lav_pkg and lav_norm.
module lav_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            right_handed,
    input  logic            q_empty,
    input  lav_pkg::item_t  q_item,
    output logic            q_pop,
    output logic            strobe,
    output lav_pkg::row_t   row
);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_NF   = 6'b000010,
        B_X1   = 6'b000100,
        B_NS   = 6'b001000,
        B_X2   = 6'b010000,
        B_DOT  = 6'b100000
    } bstate_t;

    typedef struct packed {
        logic [1:0] ia;
        logic [1:0] ib;
        logic [1:0] dst;
        logic       neg;
    } term_t;

    localparam logic [3:0] CROSS_TERMS = 4'd6;
    localparam logic [3:0] DOT_TERMS   = 4'd9;

    // Product list of a cross product: o0 = a1 b2 - a2 b1 and so on.
    function automatic term_t cross_term(input logic [3:0] k);
        term_t t;
        case (k)
            4'd0:    t = '{ia: 2'd1, ib: 2'd2, dst: 2'd0, neg: 1'b0};
            4'd1:    t = '{ia: 2'd2, ib: 2'd1, dst: 2'd0, neg: 1'b1};
            4'd2:    t = '{ia: 2'd2, ib: 2'd0, dst: 2'd1, neg: 1'b0};
            4'd3:    t = '{ia: 2'd0, ib: 2'd2, dst: 2'd1, neg: 1'b1};
            4'd4:    t = '{ia: 2'd0, ib: 2'd1, dst: 2'd2, neg: 1'b0};
            4'd5:    t = '{ia: 2'd1, ib: 2'd0, dst: 2'd2, neg: 1'b1};
            default: t = '0;
        endcase
        return t;
    endfunction

    // Product list of the eye dot products: row in dst, component in ia.
    function automatic term_t dot_term(input logic [3:0] k);
        term_t t;
        t = '0;
        case (k)
            4'd0:    begin t.dst = 2'd0; t.ia = 2'd0; end
            4'd1:    begin t.dst = 2'd0; t.ia = 2'd1; end
            4'd2:    begin t.dst = 2'd0; t.ia = 2'd2; end
            4'd3:    begin t.dst = 2'd1; t.ia = 2'd0; end
            4'd4:    begin t.dst = 2'd1; t.ia = 2'd1; end
            4'd5:    begin t.dst = 2'd1; t.ia = 2'd2; end
            4'd6:    begin t.dst = 2'd2; t.ia = 2'd0; end
            4'd7:    begin t.dst = 2'd2; t.ia = 2'd1; end
            4'd8:    begin t.dst = 2'd2; t.ia = 2'd2; end
            default: t = '0;
        endcase
        return t;
    endfunction

    // Round a Q.60 value to Q.30 (half up) and saturate to 32 bits.
    function automatic logic signed [31:0] round_sat(input logic signed [65:0] x);
        logic signed [65:0] t;
        t = (x + 66'sd536870912) >>> 30;
        if (t > 66'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (t < -66'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return t[31:0];
    endfunction

    bstate_t             state_reg;
    logic signed [31:0]  eye_reg [3];
    logic signed [31:0]  up_reg [3];
    logic signed [31:0]  fwd_reg [3];
    logic signed [31:0]  side_reg [3];
    logic signed [31:0]  upv_reg [3];
    logic                degen_reg;
    logic [3:0]          k_reg;
    logic                p_valid_reg;
    logic [1:0]          p_dst_reg;
    logic                p_neg_reg;
    logic signed [63:0]  prod_reg;
    logic signed [65:0]  acc_reg [3];
    logic signed [31:0]  bank_axis_reg [3][3];
    logic signed [31:0]  bank_off_reg [3];
    logic                bank_degen_reg;
    logic                emit_act_reg;
    logic [1:0]          emit_cnt_reg;

    term_t               term;
    logic signed [31:0]  mul_a;
    logic signed [31:0]  mul_b;
    logic                mul_state;
    logic [3:0]          n_terms;
    logic                issue;
    logic                mul_done;
    logic                n_start;
    logic [2:0][63:0]    n_vin;
    lav_pkg::norm_stat_t n_stat;
    logic [2:0][31:0]    n_out;

    lav_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (n_start),
        .vin   (n_vin),
        .stat  (n_stat),
        .vout  (n_out)
    );

    // Multiply sequencing for the cross and dot steps.
    assign mul_state = (state_reg == B_X1) || (state_reg == B_X2) || (state_reg == B_DOT);
    assign n_terms   = (state_reg == B_DOT) ? DOT_TERMS : CROSS_TERMS;
    assign issue     = mul_state && (k_reg < n_terms);
    assign mul_done  = mul_state && (k_reg == n_terms) && !p_valid_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        term  = '0;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            B_X1:
            begin
                term  = cross_term(k_reg);
                mul_a = up_reg[term.ia];
                mul_b = fwd_reg[term.ib];
            end
            B_X2:
            begin
                term  = cross_term(k_reg);
                mul_a = fwd_reg[term.ia];
                mul_b = side_reg[term.ib];
            end
            B_DOT:
            begin
                term  = dot_term(k_reg);
                mul_b = eye_reg[term.ia];
                case (term.dst)
                    lav_pkg::ROW_SIDE: mul_a = side_reg[term.ia];
                    lav_pkg::ROW_UP:   mul_a = upv_reg[term.ia];
                    default:           mul_a = fwd_reg[term.ia];
                endcase
            end
            default:
            begin
                term = '0;
            end
        endcase
    end

    // Normalize requests: the direction first, then the raw side vector.
    assign q_pop   = (state_reg == B_IDLE) && !q_empty;
    assign n_start = q_pop || ((state_reg == B_X1) && mul_done);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (state_reg == B_IDLE)
            begin
                n_vin[i] = 64'($signed(q_item.dir[i]));
            end
            else
            begin
                n_vin[i] = acc_reg[i][63:0];
            end
        end
    end

    // Main sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            degen_reg      <= 1'b0;
            k_reg          <= '0;
            p_valid_reg    <= 1'b0;
            p_dst_reg      <= '0;
            p_neg_reg      <= 1'b0;
            prod_reg       <= '0;
            bank_degen_reg <= 1'b0;
            emit_act_reg   <= 1'b0;
            emit_cnt_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                eye_reg[i]      <= '0;
                up_reg[i]       <= '0;
                fwd_reg[i]      <= '0;
                side_reg[i]     <= '0;
                upv_reg[i]      <= '0;
                acc_reg[i]      <= '0;
                bank_off_reg[i] <= '0;
                for (int j = 0; j < 3; j++)
                begin
                    bank_axis_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            // Product pipeline: issue one product, add it the next cycle.
            p_valid_reg <= issue;
            if (issue)
            begin
                prod_reg  <= mul_a * mul_b;
                p_dst_reg <= term.dst;
                p_neg_reg <= term.neg;
                k_reg     <= k_reg + 1'b1;
            end
            if (p_valid_reg)
            begin
                acc_reg[p_dst_reg] <= p_neg_reg ? (acc_reg[p_dst_reg] - 66'(prod_reg))
                                                : (acc_reg[p_dst_reg] + 66'(prod_reg));
            end

            // Row output runs alongside the next word's work.
            if (emit_act_reg)
            begin
                if (emit_cnt_reg == lav_pkg::ROW_FWD)
                begin
                    emit_act_reg <= 1'b0;
                    emit_cnt_reg <= lav_pkg::ROW_SIDE;
                end
                else
                begin
                    emit_cnt_reg <= emit_cnt_reg + 1'b1;
                end
            end

            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            eye_reg[i] <= $signed(q_item.eye[i]);
                            up_reg[i]  <= $signed(q_item.up[i]);
                        end
                        degen_reg <= q_item.fwd_zero;
                        state_reg <= B_NF;
                    end
                end
                B_NF:
                begin
                    if (n_stat.done)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            fwd_reg[i] <= $signed(n_out[i]);
                            acc_reg[i] <= '0;
                        end
                        k_reg     <= '0;
                        state_reg <= B_X1;
                    end
                end
                B_X1:
                begin
                    if (mul_done)
                    begin
                        state_reg <= B_NS;
                    end
                end
                B_NS:
                begin
                    if (n_stat.done)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            side_reg[i] <= $signed(n_out[i]);
                            acc_reg[i]  <= '0;
                        end
                        degen_reg <= degen_reg || n_stat.zero;
                        k_reg     <= '0;
                        state_reg <= B_X2;
                    end
                end
                B_X2:
                begin
                    if (mul_done)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            upv_reg[i] <= round_sat(acc_reg[i]);
                            acc_reg[i] <= '0;
                            if (right_handed)
                            begin
                                fwd_reg[i] <= -fwd_reg[i];
                            end
                        end
                        k_reg     <= '0;
                        state_reg <= B_DOT;
                    end
                end
                B_DOT:
                begin
                    if (mul_done)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            bank_axis_reg[0][i] <= side_reg[i];
                            bank_axis_reg[1][i] <= upv_reg[i];
                            bank_axis_reg[2][i] <= fwd_reg[i];
                            bank_off_reg[i]     <= round_sat(-acc_reg[i]);
                        end
                        bank_degen_reg <= degen_reg;
                        emit_act_reg   <= 1'b1;
                        emit_cnt_reg   <= lav_pkg::ROW_SIDE;
                        state_reg      <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Result word of the current row.
    assign strobe = emit_act_reg;

    always_comb
    begin
        row.row_index  = emit_cnt_reg;
        row.axis       = {bank_axis_reg[emit_cnt_reg][2], bank_axis_reg[emit_cnt_reg][1],
                          bank_axis_reg[emit_cnt_reg][0]};
        row.offset     = bank_off_reg[emit_cnt_reg];
        row.degenerate = bank_degen_reg;
        row.last_row   = (emit_cnt_reg == lav_pkg::ROW_FWD);
    end

endmodule

FILE: src/look_at_view_matrix_unit.sv
// Top level of the look-at view matrix unit: front, queue and back part.
// Depends on lav_pkg, lav_front, lav_queue, lav_back and lav_norm.
//
// A command word (eye, target, up in Q16.16) is taken at a clock edge with
// start high and busy low; busy rises only while the two-word queue is full.
// Each word gives three result words on consecutive cycles, marked by strobe:
// row 0 side, row 1 up, row 2 forward, with last_row on the third. Results are
// shown for one cycle and cannot be held off. The back part works on one word
// at a time while the queue holds up to two more, and the rows of one word go
// out while the next one is worked on: each of the two normalizations runs a
// one-bit-per-cycle range shift (up to 33 steps), a 32-step square root and
// three restoring divisions in the shared normalize unit, and the cross and dot
// products go through one 32x32 multiplier at one product a cycle.
module look_at_view_matrix_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  eye_x,
    input  logic signed [31:0]  eye_y,
    input  logic signed [31:0]  eye_z,
    input  logic signed [31:0]  target_x,
    input  logic signed [31:0]  target_y,
    input  logic signed [31:0]  target_z,
    input  logic signed [31:0]  up_x,
    input  logic signed [31:0]  up_y,
    input  logic signed [31:0]  up_z,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    output logic                strobe,
    output logic [1:0]          row_index,
    output logic signed [31:0]  axis_x,
    output logic signed [31:0]  axis_y,
    output logic signed [31:0]  axis_z,
    output logic signed [31:0]  offset,
    output logic                degenerate,
    output logic                last_row
);

    logic            right_handed_reg;
    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    lav_pkg::item_t  q_din;
    lav_pkg::item_t  q_dout;
    lav_pkg::row_t   row;

    // Handedness register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_handed_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            right_handed_reg <= cfg_wdata;
        end
    end

    lav_front u_front (
        .start    (start),
        .q_full   (q_full),
        .eye_x    (eye_x),
        .eye_y    (eye_y),
        .eye_z    (eye_z),
        .target_x (target_x),
        .target_y (target_y),
        .target_z (target_z),
        .up_x     (up_x),
        .up_y     (up_y),
        .up_z     (up_z),
        .busy     (busy),
        .push     (q_push),
        .item     (q_din)
    );

    lav_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    lav_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .right_handed (right_handed_reg),
        .q_empty      (q_empty),
        .q_item       (q_dout),
        .q_pop        (q_pop),
        .strobe       (strobe),
        .row          (row)
    );

    // Result word onto the ports.
    assign row_index  = row.row_index;
    assign axis_x     = $signed(row.axis[0]);
    assign axis_y     = $signed(row.axis[1]);
    assign axis_z     = $signed(row.axis[2]);
    assign offset     = $signed(row.offset);
    assign degenerate = row.degenerate;
    assign last_row   = row.last_row;

endmodule

FILE: src/lav_checker.sv
// Port-level checks of the row sequence of the look-at view matrix unit.
// Depends on lav_pkg; bound to look_at_view_matrix_unit.
module lav_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       strobe,
    input logic [1:0] row_index,
    input logic       degenerate,
    input logic       last_row
);

    // Only the forward row is marked last.
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (last_row == (row_index == lav_pkg::ROW_FWD)))
        else $error("last_row does not match the forward row");

    // The side row is followed at once by the up row.
    a_side_then_up: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (row_index == lav_pkg::ROW_SIDE) |=>
            strobe && (row_index == lav_pkg::ROW_UP))
        else $error("up row did not follow the side row");

    // The up row is followed at once by the forward row of the same word.
    a_up_then_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (row_index == lav_pkg::ROW_UP) |=>
            strobe && (row_index == lav_pkg::ROW_FWD) && $stable(degenerate))
        else $error("forward row did not follow the up row");

    // Row codes stay in range.
    a_row_code: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (row_index == lav_pkg::ROW_SIDE) || (row_index == lav_pkg::ROW_UP) ||
            (row_index == lav_pkg::ROW_FWD))
        else $error("row_index out of range");

endmodule

bind look_at_view_matrix_unit lav_checker u_lav_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .strobe     (strobe),
    .row_index  (row_index),
    .degenerate (degenerate),
    .last_row   (last_row)
);

FILE: tb/look_at_view_matrix_checker.sv
// Checker of the look-at view matrix unit: watches the command, config and result ports.
// It predicts the three rows of each accepted word and compares them with the results.
// Depends on nothing but the port widths of look_at_view_matrix_unit.
module look_at_view_matrix_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] up_x,
    input  logic signed [31:0] up_y,
    input  logic signed [31:0] up_z,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               strobe,
    input  logic [1:0]         row_index,
    input  logic signed [31:0] axis_x,
    input  logic signed [31:0] axis_y,
    input  logic signed [31:0] axis_z,
    input  logic signed [31:0] offset,
    input  logic               degenerate,
    input  logic               last_row,
    output int                 mismatches,
    output int                 rows_pending
);

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic signed [31:0] offset;
        logic               degenerate;
        logic               last_row;
    } view_row_t;

    typedef longint vec3_t [3];

    view_row_t  row_queue [$];
    logic       handed_copy;

    assign rows_pending = row_queue.size();

    function automatic longint clamp32(input logic signed [79:0] x);
        if (x > 80'sd2147483647)
            return 64'sd2147483647;
        if (x < -80'sd2147483648)
            return -64'sd2147483648;
        return longint'(x);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales a vector to a unit vector in Q2.30; returns 0 for a zero vector.
    function automatic bit unit_vec(input vec3_t v, output vec3_t o);
        longint unsigned mag [3];
        longint unsigned m;
        longint unsigned s;
        longint unsigned len;
        longint unsigned q;
        bit              neg [3];
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
        begin
            o = '{0, 0, 0};
            return 0;
        end
        while (m >= (64'd1 << 30))
        begin
            m = m >> 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 29))
        begin
            m = m << 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < 3; i++)
            s = s + mag[i] * mag[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << 30) + (len >> 1)) / len;
            o[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic vec3_t cross_prod(input vec3_t a, input vec3_t b);
        vec3_t o;
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
        return o;
    endfunction

    // Negated dot product with the eye, rounded to Q16.16 and saturated.
    function automatic longint eye_offset(input vec3_t ax, input vec3_t eye);
        logic signed [79:0] d;
        d = 0;
        for (int i = 0; i < 3; i++)
            d = d + 80'(ax[i]) * 80'(eye[i]);
        return clamp32((-d + (80'sd1 <<< 29)) >>> 30);
    endfunction

    // Builds the three expected rows of one command word.
    task automatic predict_rows();
        vec3_t eye;
        vec3_t dir;
        vec3_t upv;
        vec3_t fwd;
        vec3_t side;
        vec3_t raw;
        vec3_t newup;
        vec3_t axes [3];
        bit        degen;
        view_row_t r;
        eye = '{eye_x, eye_y, eye_z};
        upv = '{up_x, up_y, up_z};
        dir = '{longint'(target_x) - eye_x, longint'(target_y) - eye_y,
                longint'(target_z) - eye_z};
        degen = !unit_vec(dir, fwd);
        raw = cross_prod(upv, fwd);
        if (!unit_vec(raw, side))
            degen = 1;
        raw = cross_prod(fwd, side);
        for (int i = 0; i < 3; i++)
            newup[i] = clamp32((80'(raw[i]) + (80'sd1 <<< 29)) >>> 30);
        if (handed_copy)
            for (int i = 0; i < 3; i++)
                fwd[i] = -fwd[i];
        axes[0] = side;
        axes[1] = newup;
        axes[2] = fwd;
        for (int k = 0; k < 3; k++)
        begin
            r.row_index  = 2'(k);
            r.axis_x     = axes[k][0][31:0];
            r.axis_y     = axes[k][1][31:0];
            r.axis_z     = axes[k][2][31:0];
            r.offset     = 32'(eye_offset(axes[k], eye));
            r.degenerate = degen;
            r.last_row   = (k == 2);
            row_queue.push_back(r);
        end
    endtask

    // Track the register, predict on acceptance and compare each result word.
    always @(posedge clk or negedge rst_n)
    begin
        view_row_t e;
        if (!rst_n)
        begin
            handed_copy <= 1'b0;
            mismatches  <= 0;
        end
        else
        begin
            if (cfg_we)
                handed_copy <= cfg_wdata;
            if (start && !busy)
                predict_rows();
            if (strobe)
            begin
                if (row_queue.size() == 0)
                begin
                    $error("result word with no expected row, row_index %0d", row_index);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    e = row_queue.pop_front();
                    if (row_index !== e.row_index || axis_x !== e.axis_x
                        || axis_y !== e.axis_y || axis_z !== e.axis_z
                        || offset !== e.offset || degenerate !== e.degenerate
                        || last_row !== e.last_row)
                        mismatches <= mismatches + 1;
                    if (row_index !== e.row_index)
                        $error("row_index expected %0d actual %0d", e.row_index, row_index);
                    if (axis_x !== e.axis_x)
                        $error("axis_x expected %0d actual %0d", e.axis_x, axis_x);
                    if (axis_y !== e.axis_y)
                        $error("axis_y expected %0d actual %0d", e.axis_y, axis_y);
                    if (axis_z !== e.axis_z)
                        $error("axis_z expected %0d actual %0d", e.axis_z, axis_z);
                    if (offset !== e.offset)
                        $error("offset expected %0d actual %0d", e.offset, offset);
                    if (degenerate !== e.degenerate)
                        $error("degenerate expected %0d actual %0d", e.degenerate,
                               degenerate);
                    if (last_row !== e.last_row)
                        $error("last_row expected %0d actual %0d", e.last_row, last_row);
                end
            end
        end
    end

endmodule

FILE: tb/look_at_view_matrix_unit_test.sv
// Top of the look-at view matrix unit test: clock, reset, stimulus and verdict.
// Depends on look_at_view_matrix_unit and look_at_view_matrix_checker.
module look_at_view_matrix_unit_test;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_WORDS = 290;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] eye_x, eye_y, eye_z;
    logic signed [31:0] target_x, target_y, target_z;
    logic signed [31:0] up_x, up_y, up_z;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               strobe;
    logic [1:0]         row_index;
    logic signed [31:0] axis_x, axis_y, axis_z, offset;
    logic               degenerate;
    logic               last_row;
    int                 mismatches;
    int                 rows_pending;
    int                 idle_cycles;
    int                 burst_left;

    look_at_view_matrix_unit dut (.*);

    look_at_view_matrix_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("look_at_view_matrix_unit test failed");
            $finish;
        end
    end

    // Issues one word at a falling edge and returns once it is taken, after a random gap when a burst ends.
    task automatic send_word(input logic signed [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
        eye_x = ex;
        eye_y = ey;
        eye_z = ez;
        target_x = tx;
        target_y = ty;
        target_z = tz;
        up_x = ux;
        up_y = uy;
        up_z = uz;
        start = 1'b1;
        while (busy)
            @(negedge clk);
        @(negedge clk);
        // Bursts of random length with random gaps in between.
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 700)) @(negedge clk);
            burst_left = $urandom_range(0, 6);
        end
    endtask

    task automatic drain_then_write(input logic value);
        start = 1'b0;
        while (rows_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic directed_words();
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        // Eye equals target, and up zero or parallel to forward.
        send_word(0, 0, 0, 0, 0, 0, 0, 32'sh10000, 0);
        send_word(mx, mn, 5, mx, mn, 5, 1, 2, 3);
        send_word(0, 0, 0, 0, 0, 32'sh10000, 0, 0, 0);
        send_word(0, 0, 0, 0, 0, 32'sh10000, 0, 0, 32'sh30000);
        send_word(1, 2, 3, 5, 6, 7, -4, -4, -4);
        // Plain axis-aligned view and a few skewed ones.
        send_word(0, 0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0);
        send_word(32'sh50000, 32'sh20000, -32'sh30000, 0, 0, 0, 0, 32'sh10000, 0);
        send_word(0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_word(0, 0, 0, 0, 1, 1, 1, 0, 0);
        // Extremes of every field, with offsets that saturate.
        send_word(mx, mx, mx, mn, mn, mn, mx, mn, mx);
        send_word(mn, mn, mn, mx, mx, mx, mn, mx, mn);
        send_word(mx, mn, mx, mn, mx, mn, mn, mn, mx);
        send_word(mn, 0, 0, mx, 0, 0, 0, mx, 0);
        send_word(mx, 0, mx, mx, mx, mx, mn, 0, 0);
        send_word(-1, -1, -1, 0, 0, 0, 1, 0, 0);
        send_word(mx, mx, mx, mx, mx, mx - 1, 0, mn, 0);
        send_word(-32'sh10000, 32'sh8000, 0, mx, mn, 1, mx, mx, mx);
        send_word(mn, mn, mn, mn, mn, mn, mn, mn, mn);
    endtask

    task automatic random_words(input int count);
        logic signed [31:0] e [3];
        logic signed [31:0] t [3];
        logic signed [31:0] u [3];
        int kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 11);
            for (int i = 0; i < 3; i++)
            begin
                if (kind <= 6)
                begin
                    // Well-formed view with moderate coordinates.
                    e[i] = $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
                    t[i] = e[i] + $signed($urandom_range(0, 32'hffffff)) - 32'sh800000;
                    u[i] = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
                end
                else
                begin
                    e[i] = $urandom;
                    t[i] = $urandom;
                    u[i] = $urandom;
                end
            end
            case (kind)
                8:  t = e;
                9:  u = '{0, 0, 0};
                10:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e[i] = $signed($urandom_range(0, 32'hffffff)) - 32'sh800000;
                        t[i] = e[i] + $signed($urandom_range(0, 32'hfffff)) - 32'sh80000;
                        u[i] = t[i] - e[i];
                    end
                end
                default: ;
            endcase
            send_word(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        eye_x = 0;
        eye_y = 0;
        eye_z = 0;
        target_x = 0;
        target_y = 0;
        target_z = 0;
        up_x = 0;
        up_y = 0;
        up_z = 0;
        burst_left = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        drain_then_write(1'b0);
        directed_words();
        drain_then_write(1'b1);
        directed_words();
        random_words(RANDOM_WORDS / 2);
        drain_then_write(1'b0);
        random_words(RANDOM_WORDS / 2);

        start = 1'b0;
        while (rows_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && rows_pending == 0)
            $display("look_at_view_matrix_unit test passed");
        else
            $display("look_at_view_matrix_unit test failed");
        $finish;
    end

endmodule
